FILE: src/dcfl_pkg.sv
package dcfl_pkg;

    // Default build values
    localparam int TAPS_DEF         = 51;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field and coefficient formats
    localparam int DC_WIDTH       = 16;
    localparam int COEF_WIDTH     = 18;
    localparam int COEF_FRAC_BITS = 17;
    localparam int ROM_LEN        = 51;
    localparam int ROM_IDX_W      = $clog2(ROM_LEN);
    localparam int IDX_W          = 8;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    // Low-pass coefficients, signed Q1.17, symmetric
    localparam coef_t COEF_ROM [ROM_LEN] = '{
        18'sd0,    18'sd22,   18'sd50,   18'sd93,   18'sd155,
        18'sd244,  18'sd364,  18'sd522,  18'sd720,  18'sd962,
        18'sd1247, 18'sd1573, 18'sd1939, 18'sd2338, 18'sd2763,
        18'sd3206, 18'sd3656, 18'sd4102, 18'sd4532, 18'sd4935,
        18'sd5299, 18'sd5613, 18'sd5868, 18'sd6056, 18'sd6171,
        18'sd6210, 18'sd6171, 18'sd6056, 18'sd5868, 18'sd5613,
        18'sd5299, 18'sd4935, 18'sd4532, 18'sd4102, 18'sd3656,
        18'sd3206, 18'sd2763, 18'sd2338, 18'sd1939, 18'sd1573,
        18'sd1247, 18'sd962,  18'sd720,  18'sd522,  18'sd364,
        18'sd244,  18'sd155,  18'sd93,   18'sd50,   18'sd22,
        18'sd0
    };

    // Coefficient lookup; taps past the table weigh zero
    function automatic coef_t coef_at(input logic [IDX_W-1:0] idx);
        coef_t c;
        c = '0;
        if (idx < IDX_W'(ROM_LEN)) begin
            c = COEF_ROM[idx[ROM_IDX_W-1:0]];
        end
        return c;
    endfunction

    // Control from the sequencer to each MAC
    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctl_t;

endpackage

FILE: src/dual_channel_fir_lowpass.sv
// A result reaches m_valid after the RUN, SUM and DONE states; DONE waits until the output register is free.
// The input takes no new sample until the pass is done; the delay-line ring rotates once per sample
// past one shared multiply-accumulate unit per channel, one tap per cycle.
// A finished result waits in the output register while the next sample is taken.
// Reset (aresetn low, synchronous) clears both delay lines to zero and empties the output.
module dual_channel_fir_lowpass #(
    parameter int TAPS         = dcfl_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = dcfl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_red_ac,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_infrared_ac,
    input  logic [dcfl_pkg::DC_WIDTH-1:0]     s_red_dc,
    input  logic [dcfl_pkg::DC_WIDTH-1:0]     s_infrared_dc,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_red_ac_filtered,
    output logic signed [SAMPLE_WIDTH-1:0]    m_infrared_ac_filtered,
    output logic [dcfl_pkg::DC_WIDTH-1:0]     m_red_dc_out,
    output logic [dcfl_pkg::DC_WIDTH-1:0]     m_infrared_dc_out
);
    import dcfl_pkg::*;

    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             run;
    logic             out_free;
    logic             load_out;
    logic             shift_en;

    logic signed [SAMPLE_WIDTH-1:0] red_chain [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] ir_chain  [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] red_feed, ir_feed;
    logic signed [SAMPLE_WIDTH-1:0] red_res, ir_res;

    logic [CNT_W-1:0] coef_idx;
    coef_t            coef;
    mac_ctl_t         mac_ctl;

    logic [DC_WIDTH-1:0]           red_dc_reg, ir_dc_reg;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] red_filt_reg, ir_filt_reg;
    logic [DC_WIDTH-1:0]           red_dc_out_reg, ir_dc_out_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign run      = (state_reg == ST_RUN);
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_DONE) && out_free;
    assign shift_en = accept || run;

    // New sample enters at the head; during a run the tail wraps back around
    assign red_feed = accept ? s_red_ac      : red_chain[TAPS-1];
    assign ir_feed  = accept ? s_infrared_ac : ir_chain[TAPS-1];

    // Delay-line ring
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            dcfl_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .red_in   (red_feed),
                .ir_in    (ir_feed),
                .red_out  (red_chain[g]),
                .ir_out   (ir_chain[g])
            );
        end else begin : g_body
            dcfl_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .red_in   (red_chain[g-1]),
                .ir_in    (ir_chain[g-1]),
                .red_out  (red_chain[g]),
                .ir_out   (ir_chain[g])
            );
        end
    end

    // Tail of the ring holds the oldest remaining tap of this pass
    assign coef_idx = CNT_W'(TAPS - 1) - cnt_reg;
    assign coef     = coef_at(IDX_W'(coef_idx));

    assign mac_ctl.clear  = accept;
    assign mac_ctl.mul_en = run;

    dcfl_mac #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .TAPS(TAPS)) u_mac_red (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef    (coef),
        .tap     (red_chain[TAPS-1]),
        .result  (red_res)
    );

    dcfl_mac #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .TAPS(TAPS)) u_mac_ir (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef    (coef),
        .tap     (ir_chain[TAPS-1]),
        .result  (ir_res)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TAPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // DC levels ride along with the transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            red_dc_reg <= s_red_dc;
            ir_dc_reg  <= s_infrared_dc;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            red_filt_reg   <= red_res;
            ir_filt_reg    <= ir_res;
            red_dc_out_reg <= red_dc_reg;
            ir_dc_out_reg  <= ir_dc_reg;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_red_ac_filtered      = red_filt_reg;
    assign m_infrared_ac_filtered = ir_filt_reg;
    assign m_red_dc_out           = red_dc_out_reg;
    assign m_infrared_dc_out      = ir_dc_out_reg;

endmodule

FILE: src/dcfl_cell.sv
module dcfl_cell #(
    parameter int SAMPLE_WIDTH = dcfl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           shift_en,
    input  logic signed [SAMPLE_WIDTH-1:0] red_in,
    input  logic signed [SAMPLE_WIDTH-1:0] ir_in,
    output logic signed [SAMPLE_WIDTH-1:0] red_out,
    output logic signed [SAMPLE_WIDTH-1:0] ir_out
);

    logic signed [SAMPLE_WIDTH-1:0] red_reg;
    logic signed [SAMPLE_WIDTH-1:0] ir_reg;

    // One delay-line slot per channel; takes the neighbor's value on shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg <= '0;
            ir_reg  <= '0;
        end else if (shift_en) begin
            red_reg <= red_in;
            ir_reg  <= ir_in;
        end
    end

    assign red_out = red_reg;
    assign ir_out  = ir_reg;

endmodule

FILE: src/dcfl_mac.sv
module dcfl_mac #(
    parameter int SAMPLE_WIDTH = dcfl_pkg::SAMPLE_WIDTH_DEF,
    parameter int TAPS         = dcfl_pkg::TAPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dcfl_pkg::mac_ctl_t             ctl,
    input  dcfl_pkg::coef_t                coef,
    input  logic signed [SAMPLE_WIDTH-1:0] tap,
    output logic signed [SAMPLE_WIDTH-1:0] result
);
    import dcfl_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAPS + 1);
    localparam int Q_W    = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] BIAS =
        ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  biased;
    logic signed [Q_W-1:0]    quot;
    logic [Q_W-SAMPLE_WIDTH:0] top_bits;

    assign prod_next = tap * coef;

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.mul_en;
        end
        prod_reg <= prod_next;
    end

    // Accumulate stage, full precision
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Scale down with truncation toward zero, then saturate
    always_comb begin
        biased   = acc_reg + (acc_reg[ACC_W-1] ? BIAS : '0);
        quot     = biased[ACC_W-1:COEF_FRAC_BITS];
        top_bits = quot[Q_W-1:SAMPLE_WIDTH-1];
        if (top_bits == '0 || top_bits == '1) begin
            result = quot[SAMPLE_WIDTH-1:0];
        end else if (quot[Q_W-1]) begin
            result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

endmodule

FILE: src/dcfl_checker.sv
module dcfl_checker #(
    parameter int SAMPLE_WIDTH = dcfl_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_red_ac_filtered,
    input logic signed [SAMPLE_WIDTH-1:0] m_infrared_ac_filtered,
    input logic [dcfl_pkg::DC_WIDTH-1:0]  m_red_dc_out,
    input logic [dcfl_pkg::DC_WIDTH-1:0]  m_infrared_dc_out
);

    // Reset empties the output and leaves the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty or input closed after reset");

    // One sample at a time: input is checked closed at the start of each filter pass
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input reopened during a filter pass");

    // A new result is posted only as the sequencer returns to idle
    a_result_ends_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result posted while a pass is still running");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_ac_filtered)
            && $stable(m_infrared_ac_filtered) && $stable(m_red_dc_out)
            && $stable(m_infrared_dc_out))
        else $error("stalled result changed or dropped");

endmodule

bind dual_channel_fir_lowpass dcfl_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dcfl_checker (
    .aclk                   (aclk),
    .aresetn                (aresetn),
    .s_valid                (s_valid),
    .s_ready                (s_ready),
    .m_valid                (m_valid),
    .m_ready                (m_ready),
    .m_red_ac_filtered      (m_red_ac_filtered),
    .m_infrared_ac_filtered (m_infrared_ac_filtered),
    .m_red_dc_out           (m_red_dc_out),
    .m_infrared_dc_out      (m_infrared_dc_out)
);

FILE: tb/tb_dual_channel_fir_lowpass.sv
module tb_dual_channel_fir_lowpass;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS       = 51;
    localparam int SW          = 16;
    localparam int DCW         = dcfl_pkg::DC_WIDTH;
    localparam int FRAC        = 17;
    localparam int RAND_ITEMS  = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 600;

    typedef struct packed {
        logic signed [SW-1:0] red_ac;
        logic signed [SW-1:0] infrared_ac;
        logic [DCW-1:0]       red_dc;
        logic [DCW-1:0]       infrared_dc;
        logic                 may_idle;
    } oxi_sample_t;

    typedef struct packed {
        logic signed [SW-1:0] red_filt;
        logic signed [SW-1:0] infrared_filt;
        logic [DCW-1:0]       red_dc;
        logic [DCW-1:0]       infrared_dc;
    } oxi_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic signed [SW-1:0] s_red_ac      = '0;
    logic signed [SW-1:0] s_infrared_ac = '0;
    logic [DCW-1:0]       s_red_dc      = '0;
    logic [DCW-1:0]       s_infrared_dc = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic signed [SW-1:0] m_red_ac_filtered;
    logic signed [SW-1:0] m_infrared_ac_filtered;
    logic [DCW-1:0]       m_red_dc_out;
    logic [DCW-1:0]       m_infrared_dc_out;

    // Stimulus and expected filter outputs
    oxi_sample_t pending_samples[$];
    oxi_result_t filtered_expected[$];

    // Filter copy: tap weights and both delay lines, newest at index 0
    int                   lp_coef [NTAPS];
    logic signed [SW-1:0] delay_line [2][NTAPS];

    int send_gap    = 0;
    int recv_stall  = 0;
    int hold_left   = 0;
    int hold_seen   = 0;
    int sent_count  = 0;
    int recv_count  = 0;
    int error_count = 0;
    int cycle_count = 0;

    dual_channel_fir_lowpass dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_red_ac               (s_red_ac),
        .s_infrared_ac          (s_infrared_ac),
        .s_red_dc               (s_red_dc),
        .s_infrared_dc          (s_infrared_dc),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_red_ac_filtered      (m_red_ac_filtered),
        .m_infrared_ac_filtered (m_infrared_ac_filtered),
        .m_red_dc_out           (m_red_dc_out),
        .m_infrared_dc_out      (m_infrared_dc_out)
    );

    always #5 aclk = ~aclk;

    // Shift a sample into one delay line and return the scaled, saturated sum
    function automatic logic signed [SW-1:0] lowpass_push(input int ch,
                                                          input logic signed [SW-1:0] smp);
        longint acc;
        longint q;
        acc = 0;
        for (int i = NTAPS - 1; i > 0; i--) begin
            delay_line[ch][i] = delay_line[ch][i-1];
        end
        delay_line[ch][0] = smp;
        for (int i = 0; i < NTAPS; i++) begin
            acc += longint'(lp_coef[i]) * longint'(delay_line[ch][i]);
        end
        // truncate toward zero, not floor
        if (acc < 0) begin
            q = -((-acc) >>> FRAC);
        end else begin
            q = acc >>> FRAC;
        end
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return SW'(q);
    endfunction

    function automatic void queue_sample(input logic signed [SW-1:0] ra,
                                         input logic signed [SW-1:0] ia,
                                         input logic [DCW-1:0] rd,
                                         input logic [DCW-1:0] id,
                                         input logic idle);
        oxi_sample_t smp;
        smp.red_ac      = ra;
        smp.infrared_ac = ia;
        smp.red_dc      = rd;
        smp.infrared_dc = id;
        smp.may_idle    = idle;
        pending_samples.push_back(smp);
    endfunction

    // Driver: offer queued samples, predict on each accepted transaction
    always @(posedge aclk) begin : drive_samples
        oxi_sample_t nxt;
        oxi_result_t want;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                want.red_filt      = lowpass_push(0, s_red_ac);
                want.infrared_filt = lowpass_push(1, s_infrared_ac);
                want.red_dc        = s_red_dc;
                want.infrared_dc   = s_infrared_dc;
                filtered_expected.push_back(want);
                sent_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    nxt = pending_samples.pop_front();
                    s_red_ac      <= nxt.red_ac;
                    s_infrared_ac <= nxt.infrared_ac;
                    s_red_dc      <= nxt.red_dc;
                    s_infrared_dc <= nxt.infrared_dc;
                    s_valid       <= 1'b1;
                    send_gap      <= nxt.may_idle ? int'($urandom_range(0, 9)) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once after a number of result transactions
    always @(posedge aclk) begin : hold_off
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                hold_seen <= hold_seen + 1;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (m_valid && m_ready && hold_seen == HOLD_AT - 1) begin
                hold_left <= HOLD_LEN;
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction
    always @(posedge aclk) begin : check_results
        oxi_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (filtered_expected.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected result: red %0d ir %0d rdc %0d irdc %0d",
                                 m_red_ac_filtered, m_infrared_ac_filtered,
                                 m_red_dc_out, m_infrared_dc_out);
                    end
                end else begin
                    want = filtered_expected.pop_front();
                    if (m_red_ac_filtered !== want.red_filt ||
                        m_infrared_ac_filtered !== want.infrared_filt ||
                        m_red_dc_out !== want.red_dc ||
                        m_infrared_dc_out !== want.infrared_dc) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("mismatch at result %0d: exp red %0d ir %0d rdc %0d irdc %0d",
                                     recv_count, want.red_filt, want.infrared_filt,
                                     want.red_dc, want.infrared_dc);
                            $display("    got red %0d ir %0d rdc %0d irdc %0d",
                                     m_red_ac_filtered, m_infrared_ac_filtered,
                                     m_red_dc_out, m_infrared_dc_out);
                        end
                    end
                end
                recv_count++;
                // every third window of results runs without stalls
                recv_stall = (((recv_count / 128) % 3) == 1) ? 0 : int'($urandom_range(0, 9));
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, filtered_expected.size());
            $display("tb_dual_channel_fir_lowpass: done, errors");
            $finish;
        end
    end

    initial begin : run_test
        int n;
        int kind;
        int len;
        logic idle;
        logic signed [SW-1:0] ra;
        logic signed [SW-1:0] ia;
        logic [DCW-1:0] rd;
        logic [DCW-1:0] id;

        lp_coef = '{
            0, 22, 50, 93, 155, 244, 364, 522, 720, 962,
            1247, 1573, 1939, 2338, 2763, 3206, 3656, 4102, 4532, 4935,
            5299, 5613, 5868, 6056, 6171, 6210, 6171, 6056, 5868, 5613,
            5299, 4935, 4532, 4102, 3656, 3206, 2763, 2338, 1939, 1573,
            1247, 962, 720, 522, 364, 244, 155, 93, 50, 22,
            0
        };
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < NTAPS; i++) begin
                delay_line[c][i] = '0;
            end
        end

        // Directed: field extremes, alternating bit patterns, small negatives that truncate toward zero
        queue_sample(16'sd0, 16'sd0, 16'h0000, 16'h0000, 1'b0);
        queue_sample(16'sd32767, -16'sd32768, 16'hFFFF, 16'h0000, 1'b0);
        queue_sample(-16'sd32768, 16'sd32767, 16'h0000, 16'hFFFF, 1'b0);
        queue_sample(-16'sd1, 16'sd1, 16'h5555, 16'hAAAA, 1'b1);
        queue_sample(16'sd1, -16'sd1, 16'hAAAA, 16'h5555, 1'b1);
        queue_sample(16'sh5555, 16'shAAAA, 16'h8000, 16'h7FFF, 1'b0);
        queue_sample(16'shAAAA, 16'sh5555, 16'h7FFF, 16'h8000, 1'b0);
        queue_sample(-16'sd2, -16'sd3, 16'h0001, 16'hFFFE, 1'b1);
        for (int k = 0; k < 8; k++) begin
            queue_sample(16'sd32767, -16'sd32768, 16'hFFFF, 16'hFFFF, 1'b0);
        end
        for (int k = 0; k < 8; k++) begin
            queue_sample(-16'sd32768, 16'sd32767, 16'h0000, 16'h0000, k[0]);
        end

        // Random segments: full range, long constant runs, small values, alternation
        n = 0;
        while (n < RAND_ITEMS) begin
            kind = $urandom_range(0, 3);
            len  = (kind == 1) ? $urandom_range(55, 90) : $urandom_range(8, 80);
            idle = ($urandom_range(0, 2) != 0);
            ra   = SW'($urandom);
            ia   = SW'($urandom);
            if (kind == 1 && $urandom_range(0, 1) == 1) begin
                ra = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                ia = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            end
            for (int k = 0; k < len; k++) begin
                rd = DCW'($urandom);
                id = DCW'($urandom);
                case (kind)
                    0: begin
                        ra = SW'($urandom);
                        ia = SW'($urandom);
                    end
                    2: begin
                        ra = SW'(int'($urandom_range(0, 16)) - 8);
                        ia = SW'(int'($urandom_range(0, 16)) - 8);
                    end
                    3: begin
                        ra = k[0] ? 16'sd32767 : -16'sd32768;
                        ia = k[0] ? -16'sd32768 : 16'sd32767;
                    end
                    default: begin
                    end
                endcase
                queue_sample(ra, ia, rd, id, idle);
            end
            n += len;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all samples accepted and every prediction matched
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || filtered_expected.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d samples (directed extremes, then random runs) and checked %0d results",
                 sent_count, recv_count);
        $display("output stalled once for %0d cycles to back up the input side", HOLD_LEN);
        if (error_count == 0 && filtered_expected.size() == 0) begin
            $display("tb_dual_channel_fir_lowpass: done, clean");
        end else begin
            $display("%0d errors", error_count);
            $display("tb_dual_channel_fir_lowpass: done, errors");
        end
        $finish;
    end

endmodule
